// File: rtl/bimodal_gshare_branch_predictor_assert.svh
// Assertion macros for the branch predictor block.
// Included by the top level; depends on nothing else.
`ifndef BIMODAL_GSHARE_BRANCH_PREDICTOR_ASSERT_SVH
`define BIMODAL_GSHARE_BRANCH_PREDICTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BGP_ASSERT_SAME(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("branch predictor check failed");
`define BGP_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> post) \
    else $error("branch predictor check failed");
`else
`define BGP_ASSERT_SAME(lbl, clk, rst_n, pre, post)
`define BGP_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// File: rtl/bgp_pkg.sv
// Shared types, codes and helper functions of the branch predictor.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none
package bgp_pkg;

  localparam int INDEX_BITS  = 12;
  localparam int TABLE_DEPTH = 1 << INDEX_BITS;
  localparam int HIST_LEN_W  = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 4;
  localparam int PC_W        = 32;

  localparam logic [1:0] CTR_RESET = 2'd1;
  localparam logic [1:0] CTR_MAX   = 2'd3;
  localparam logic [1:0] CTR_MIN   = 2'd0;

  localparam logic CMD_PREDICT = 1'b0;
  localparam logic CMD_TRAIN   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIST = 1'b1;

  localparam logic [HIST_LEN_W-1:0] HIST_LEN_RESET = HIST_LEN_W'(INDEX_BITS);

  typedef logic [INDEX_BITS-1:0] idx_t;

  typedef enum logic [1:0] {
    MODE_STATIC  = 2'd0,
    MODE_BIMODAL = 2'd1,
    MODE_GSHARE  = 2'd2,
    MODE_UNIMPL  = 2'd3
  } mode_t;

  typedef struct packed {
    logic clr_en;
    logic accept;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_pred;
    logic out_blocked;
  } ctl_stat_t;

  function automatic idx_t hist_mask(input logic [HIST_LEN_W-1:0] len);
    idx_t m;
    m = '0;
    for (int i = 0; i < INDEX_BITS; i++) begin
      m[i] = (i < int'(len));
    end
    return m;
  endfunction

  function automatic logic [1:0] ctr_update(input logic [1:0] c, input logic dir);
    logic [1:0] n;
    n = c;
    if (dir) begin
      if (c != CTR_MAX) n = c + 2'd1;
    end else begin
      if (c != CTR_MIN) n = c - 2'd1;
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// File: rtl/bimodal_gshare_branch_predictor.sv
// Top level of the branch predictor: controller plus datapath, and assertions.
// Depends on bgp_pkg, bgp_ctrl, bgp_datapath and the assertion macro header.
`default_nettype none
`include "bimodal_gshare_branch_predictor_assert.svh"
// A predict or train beat is taken when in_valid is high and in_stall low. Each
// beat has two steps: the first reads the 4096-entry counter table through
// its registered read port, the second evaluates the counter and either loads
// the result register (predict) or writes the updated counter back (train), so
// a new beat is taken only once the last one is done. A predict waits in the
// second step only while an earlier result is still held by out_stall. After
// reset the table is cleared to weakly not taken, one entry per cycle, over all
// 4096 entries; in_stall stays high during that pass while configuration writes
// are accepted. Writes to the configuration registers are accepted every cycle
// (cfg_ready is always high) and are meant to happen while no beat is in flight.
module bimodal_gshare_branch_predictor (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_cmd,
  input  logic [bgp_pkg::PC_W-1:0]       in_pc,
  input  logic                           in_outcome,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_taken,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bgp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bgp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bgp_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;
  logic      in_acc;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;

  bgp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  bgp_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_cmd     (in_cmd),
    .in_pc      (in_pc),
    .in_outcome (in_outcome),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_taken  (out_taken)
  );

  `BGP_ASSERT_NEXT(a_stall_after_accept, clk, rst_n, in_acc, in_stall)
  `BGP_ASSERT_SAME(a_no_result_in_clear, clk, rst_n, cmd.clr_en, !out_valid && in_stall)
  `BGP_ASSERT_NEXT(a_train_no_result, clk, rst_n, in_acc && (in_cmd == CMD_TRAIN) && !out_valid, ##1 !out_valid)
  `BGP_ASSERT_SAME(a_single_action, clk, rst_n, 1'b1, !(cmd.clr_en && (cmd.accept || cmd.commit)))

endmodule
`default_nettype wire

// File: rtl/bgp_ctrl.sv
// Sequencing state machine of the branch predictor: table clear, accept, commit.
// Depends on bgp_pkg; drives the datapath through ctl_cmd_t.
`default_nettype none
module bgp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  bgp_pkg::ctl_stat_t stat,
  output bgp_pkg::ctl_cmd_t  cmd,
  output logic               in_stall
);
  import bgp_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_stall_r;
  logic   in_stall_nxt;

  always_comb begin
    cmd.clr_en = (state_r == ST_CLEAR);
    cmd.accept = (state_r == ST_IDLE) && in_valid;
    cmd.commit = (state_r == ST_EVAL) && !(stat.is_pred && stat.out_blocked);
    state_nxt  = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (cmd.commit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
    in_stall_nxt = (state_nxt != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      in_stall_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= in_stall_nxt;
    end
  end

  assign in_stall = in_stall_r;

endmodule
`default_nettype wire

// File: rtl/bgp_datapath.sv
// Datapath of the branch predictor: counter table, history, config, result register.
// Depends on bgp_pkg; steered by bgp_ctrl through ctl_cmd_t.
`default_nettype none
module bgp_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bgp_pkg::ctl_cmd_t                 cmd,
  output bgp_pkg::ctl_stat_t                stat,
  input  logic                              in_cmd,
  input  logic [bgp_pkg::PC_W-1:0]          in_pc,
  input  logic                              in_outcome,
  input  logic                              cfg_valid,
  input  logic [bgp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bgp_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_taken
);
  import bgp_pkg::*;

  logic [1:0]            mem [TABLE_DEPTH];
  idx_t                  clr_cnt_r;
  idx_t                  hist_r;
  idx_t                  idx_r;
  idx_t                  idx_comb;
  idx_t                  mask;
  idx_t                  wr_addr;
  logic [1:0]            wr_data;
  logic                  wr_en;
  logic [1:0]            rd_data_r;
  logic                  cmd_r;
  logic                  outcome_r;
  mode_t                 mode_r;
  logic [HIST_LEN_W-1:0] hist_len_r;
  logic                  out_valid_r;
  logic                  out_taken_r;
  logic                  taken;
  logic                  train_go;

  assign mask     = hist_mask(hist_len_r);
  assign idx_comb = (mode_r == MODE_GSHARE) ? ((in_pc[INDEX_BITS-1:0] ^ hist_r) & mask)
                                            : in_pc[INDEX_BITS-1:0];

  always_comb begin
    case (mode_r)
      MODE_STATIC:  taken = 1'b1;
      MODE_BIMODAL: taken = rd_data_r[1];
      MODE_GSHARE:  taken = rd_data_r[1];
      default:      taken = 1'b0;
    endcase
  end

  assign train_go = cmd.commit && (cmd_r == CMD_TRAIN) && (mode_r != MODE_UNIMPL);
  assign wr_en    = cmd.clr_en || train_go;
  assign wr_addr  = cmd.clr_en ? clr_cnt_r : idx_r;
  assign wr_data  = cmd.clr_en ? CTR_RESET : ctr_update(rd_data_r, outcome_r);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) rd_data_r <= mem[idx_comb];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r     <= in_cmd;
      outcome_r <= in_outcome;
      idx_r     <= idx_comb;
    end
    if (cmd.commit && (cmd_r == CMD_PREDICT)) out_taken_r <= taken;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      hist_r      <= '0;
      mode_r      <= MODE_BIMODAL;
      hist_len_r  <= HIST_LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_en) clr_cnt_r <= clr_cnt_r + idx_t'(1);
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MODE: mode_r     <= mode_t'(cfg_data[1:0]);
          CFG_HIST: hist_len_r <= cfg_data[HIST_LEN_W-1:0];
          default:  ;
        endcase
      end
      if (train_go && (mode_r == MODE_GSHARE)) begin
        hist_r <= (((hist_r & mask) << 1) | idx_t'(outcome_r)) & mask;
      end
      if (cmd.commit && (cmd_r == CMD_PREDICT)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.clr_last    = (clr_cnt_r == '1);
  assign stat.is_pred     = (cmd_r == CMD_PREDICT);
  assign stat.out_blocked = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_taken = out_taken_r;

endmodule
`default_nettype wire
